// ----- sv/go_back_n_link_endpoint_assert.svh -----
// assertion macros for the go-back-n link endpoint checker
// expects clk and rst_n in the scope of each use
`ifndef GO_BACK_N_LINK_ENDPOINT_ASSERT_SVH
`define GO_BACK_N_LINK_ENDPOINT_ASSERT_SVH

// checked only while out of reset
`define GBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GBN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/gbn_pkg.sv -----
// shared constants, codes and control structs for the go-back-n endpoint
// no dependencies
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int DATA_W  = 64;
  localparam int SEQ_W   = 3;
  localparam int SEQ_MOD = 8;
  localparam int ACT_W   = 2;
  localparam int KIND_W  = 2;

  localparam logic [SEQ_W-1:0] MAX_SEQ = 3'd7;

  localparam logic [ACT_W-1:0] ACT_SEND    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RECV    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CKSUM   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_TX      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REFUSE  = 2'd3;

  typedef struct packed {
    logic send;
    logic recv;
    logic refuse;
    logic status;
    logic rp_start;
    logic rp_active;
  } gbn_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic window_full;
    logic rp_last;
  } gbn_sts_t;

endpackage

// ----- sv/go_back_n_link_endpoint.sv -----
// go-back-n link endpoint: send, receive, timeout and checksum-error commands
// latency: one result in the cycle after the transfer for send, receive, checksum error
// and an empty timeout; busy stays low, so such commands can go every cycle
// timeout with n frames buffered: n frames back to back from the store read port, busy high meanwhile
// reset: synchronous active-low rst_n clears sequence state, store contents stay undefined
`timescale 1ns / 1ps

module go_back_n_link_endpoint import gbn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [DATA_W-1:0] in_packet_data,
  input  logic [SEQ_W-1:0]  in_frame_seq,
  input  logic [SEQ_W-1:0]  in_frame_ack,
  output logic              out_valid,
  output logic [KIND_W-1:0] out_kind,
  output logic [DATA_W-1:0] out_payload,
  output logic [SEQ_W-1:0]  out_seq,
  output logic [SEQ_W-1:0]  out_ack,
  output logic              out_window_open,
  output logic              out_last
);

  gbn_cmd_t cmd;
  gbn_sts_t sts;

  gbn_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  gbn_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .packet_data     (in_packet_data),
    .frame_seq       (in_frame_seq),
    .frame_ack       (in_frame_ack),
    .sts             (sts),
    .res_valid       (out_valid),
    .res_kind        (out_kind),
    .res_payload     (out_payload),
    .res_seq         (out_seq),
    .res_ack         (out_ack),
    .res_window_open (out_window_open),
    .res_last        (out_last)
  );

endmodule

// ----- sv/gbn_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module gbn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/gbn_ctrl.sv -----
// control state machine: decodes accepted commands and runs the replay
// depends on gbn_pkg
`timescale 1ns / 1ps

module gbn_ctrl import gbn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACT_W-1:0] action,
  input  gbn_sts_t         sts,
  output gbn_cmd_t         cmd,
  output logic             busy
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REPLAY = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r == ST_REPLAY);

  always_comb begin
    cmd           = '0;
    cmd.rp_active = (state_r == ST_REPLAY);
    if (accept) begin
      unique case (action)
        ACT_SEND: begin
          cmd.send   = !sts.window_full;
          cmd.refuse = sts.window_full;
        end
        ACT_RECV: begin
          cmd.recv = 1'b1;
        end
        ACT_TIMEOUT: begin
          cmd.status   = sts.count_zero;
          cmd.rp_start = !sts.count_zero;
        end
        ACT_CKSUM: begin
          cmd.status = 1'b1;
        end
        default: begin
          cmd.status = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.rp_start) begin
          state_nxt = ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        if (sts.rp_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/gbn_datapath.sv -----
// sequence registers, window arithmetic, packet store and result registers
// depends on gbn_pkg and gbn_ram
`timescale 1ns / 1ps

module gbn_datapath import gbn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  gbn_cmd_t          cmd,
  input  logic [DATA_W-1:0] packet_data,
  input  logic [SEQ_W-1:0]  frame_seq,
  input  logic [SEQ_W-1:0]  frame_ack,
  output gbn_sts_t          sts,
  output logic              res_valid,
  output logic [KIND_W-1:0] res_kind,
  output logic [DATA_W-1:0] res_payload,
  output logic [SEQ_W-1:0]  res_seq,
  output logic [SEQ_W-1:0]  res_ack,
  output logic              res_window_open,
  output logic              res_last
);

  logic [SEQ_W-1:0] next_r, next_nxt;
  logic [SEQ_W-1:0] oldest_r, oldest_nxt;
  logic [SEQ_W-1:0] expected_r, expected_nxt;
  logic [SEQ_W-1:0] count_r, count_nxt;
  logic [SEQ_W-1:0] rp_seq_r, rp_seq_nxt;
  logic [SEQ_W-1:0] rp_left_r, rp_left_nxt;

  logic              sv_valid_r;
  logic [KIND_W-1:0] sv_kind_r, sv_kind_nxt;
  logic [DATA_W-1:0] sv_payload_r, sv_payload_nxt;
  logic [SEQ_W-1:0]  sv_seq_r, sv_seq_nxt;
  logic [SEQ_W-1:0]  sv_ack_r, sv_ack_nxt;
  logic              sv_win_r;

  logic [SEQ_W-1:0]  piggy;
  logic [SEQ_W-1:0]  ack_off;
  logic              ack_in_win;
  logic [SEQ_W-1:0]  rel_cnt;
  logic              deliver;
  logic [SEQ_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;

  assign piggy      = expected_r + MAX_SEQ;
  assign ack_off    = frame_ack - oldest_r;
  assign ack_in_win = (ack_off < count_r);
  assign rel_cnt    = ack_off + 3'd1;
  assign deliver    = (frame_seq == expected_r);

  assign sts.count_zero  = (count_r == '0);
  assign sts.window_full = (count_r >= MAX_SEQ);
  assign sts.rp_last     = (rp_left_r == 3'd1);

  // replay reads run one slot ahead of the frame on the output
  assign raddr = cmd.rp_active ? rp_seq_r + 3'd1 : oldest_r;

  gbn_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SEQ_MOD)
  ) u_store (
    .clk   (clk),
    .we    (cmd.send),
    .waddr (next_r),
    .wdata (packet_data),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    next_nxt       = next_r;
    oldest_nxt     = oldest_r;
    expected_nxt   = expected_r;
    count_nxt      = count_r;
    rp_seq_nxt     = rp_seq_r;
    rp_left_nxt    = rp_left_r;
    sv_kind_nxt    = KIND_STATUS;
    sv_payload_nxt = '0;
    sv_seq_nxt     = '0;
    sv_ack_nxt     = '0;
    priority if (cmd.send) begin
      next_nxt       = next_r + 3'd1;
      count_nxt      = count_r + 3'd1;
      sv_kind_nxt    = KIND_TX;
      sv_payload_nxt = packet_data;
      sv_seq_nxt     = next_r;
      sv_ack_nxt     = piggy;
    end else if (cmd.recv) begin
      if (deliver) begin
        expected_nxt   = expected_r + 3'd1;
        sv_kind_nxt    = KIND_DELIVER;
        sv_payload_nxt = packet_data;
      end
      if (ack_in_win) begin
        oldest_nxt = frame_ack + 3'd1;
        count_nxt  = count_r - rel_cnt;
      end
    end else if (cmd.refuse) begin
      sv_kind_nxt = KIND_REFUSE;
    end else if (cmd.rp_start) begin
      rp_seq_nxt  = oldest_r;
      rp_left_nxt = count_r;
    end else if (cmd.rp_active) begin
      rp_seq_nxt  = rp_seq_r + 3'd1;
      rp_left_nxt = rp_left_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r     <= '0;
      oldest_r   <= '0;
      expected_r <= '0;
      count_r    <= '0;
      sv_valid_r <= 1'b0;
    end else begin
      next_r     <= next_nxt;
      oldest_r   <= oldest_nxt;
      expected_r <= expected_nxt;
      count_r    <= count_nxt;
      sv_valid_r <= cmd.send || cmd.recv || cmd.refuse || cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    rp_seq_r     <= rp_seq_nxt;
    rp_left_r    <= rp_left_nxt;
    sv_kind_r    <= sv_kind_nxt;
    sv_payload_r <= sv_payload_nxt;
    sv_seq_r     <= sv_seq_nxt;
    sv_ack_r     <= sv_ack_nxt;
    sv_win_r     <= (count_nxt < MAX_SEQ);
  end

  // replay frames come straight from the registered store read
  always_comb begin
    if (cmd.rp_active) begin
      res_valid       = 1'b1;
      res_kind        = KIND_TX;
      res_payload     = rdata;
      res_seq         = rp_seq_r;
      res_ack         = piggy;
      res_window_open = (count_r < MAX_SEQ);
      res_last        = (rp_left_r == 3'd1);
    end else begin
      res_valid       = sv_valid_r;
      res_kind        = sv_kind_r;
      res_payload     = sv_payload_r;
      res_seq         = sv_seq_r;
      res_ack         = sv_ack_r;
      res_window_open = sv_win_r;
      res_last        = 1'b1;
    end
  end

endmodule

// ----- sv/gbn_checker.sv -----
// port-level assertions for the go-back-n link endpoint, bound to the top level
// depends on gbn_pkg and go_back_n_link_endpoint_assert.svh
`timescale 1ns / 1ps
`include "go_back_n_link_endpoint_assert.svh"

module gbn_checker import gbn_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_valid,
  input logic [KIND_W-1:0] out_kind,
  input logic              out_window_open,
  input logic              out_last
);

  `GBN_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !busy, "output active after reset")
  `GBN_ASSERT(a_replay_streams, busy |-> out_valid && out_kind == KIND_TX, "gap in replay")
  `GBN_ASSERT(a_busy_ends_on_last, $fell(busy) && $past(rst_n) |-> $past(out_valid && out_last), "replay ended without last frame")
  `GBN_ASSERT(a_refuse_when_full, out_valid && out_kind == KIND_REFUSE |-> !out_window_open && out_last, "refusal with open window")

endmodule

bind go_back_n_link_endpoint gbn_checker u_gbn_checker (.*);

// ----- test/go_back_n_link_endpoint_checker.sv -----
// checker for the go-back-n link endpoint: watches command and result transfers,
// predicts the result stream from its own copy of the link state and compares
// depends on gbn_pkg
`timescale 1ns / 1ps

module go_back_n_link_endpoint_checker import gbn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [DATA_W-1:0] in_packet_data,
  input  logic [SEQ_W-1:0]  in_frame_seq,
  input  logic [SEQ_W-1:0]  in_frame_ack,
  input  logic              out_valid,
  input  logic [KIND_W-1:0] out_kind,
  input  logic [DATA_W-1:0] out_payload,
  input  logic [SEQ_W-1:0]  out_seq,
  input  logic [SEQ_W-1:0]  out_ack,
  input  logic              out_window_open,
  input  logic              out_last,
  output int                mismatches,
  output int                pending
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] payload;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  ack;
    logic              window_open;
    logic              last;
  } link_result_t;

  logic [SEQ_W-1:0]  next_seq;
  logic [SEQ_W-1:0]  base_seq;
  logic [SEQ_W-1:0]  expect_seq;
  logic [SEQ_W-1:0]  sent_count;
  logic [DATA_W-1:0] frame_store [SEQ_MOD];

  link_result_t expected_results[$];
  link_result_t head;
  int mismatch_count = 0;

  assign mismatches = mismatch_count;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  // true when lo <= a < hi going around the sequence space
  function automatic logic ack_in_window(input logic [SEQ_W-1:0] lo,
                                         input logic [SEQ_W-1:0] a,
                                         input logic [SEQ_W-1:0] hi);
    return ((lo <= a) && (a < hi)) || ((hi < lo) && (lo <= a)) || ((a < hi) && (hi < lo));
  endfunction

  function automatic void add_expected(input logic [KIND_W-1:0] kind,
                                       input logic [DATA_W-1:0] payload,
                                       input logic [SEQ_W-1:0] seq,
                                       input logic [SEQ_W-1:0] ack,
                                       input logic last);
    link_result_t r;
    r.kind        = kind;
    r.payload     = payload;
    r.seq         = seq;
    r.ack         = ack;
    r.window_open = (sent_count < MAX_SEQ);
    r.last        = last;
    expected_results.push_back(r);
  endfunction

  task automatic predict_link(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] data,
                              input logic [SEQ_W-1:0] fseq, input logic [SEQ_W-1:0] fack);
    logic [SEQ_W-1:0] slot;
    logic             deliver;
    int               i;
    case (act)
      ACT_SEND: begin
        if (sent_count >= MAX_SEQ) begin
          add_expected(KIND_REFUSE, '0, '0, '0, 1'b1);
        end else begin
          slot = next_seq;
          frame_store[slot] = data;
          sent_count = sent_count + 1'b1;
          next_seq = next_seq + 1'b1;
          add_expected(KIND_TX, data, slot, expect_seq - 1'b1, 1'b1);
        end
      end
      ACT_RECV: begin
        deliver = (fseq == expect_seq);
        if (deliver) expect_seq = expect_seq + 1'b1;
        while (sent_count != 0 && ack_in_window(base_seq, fack, next_seq)) begin
          sent_count = sent_count - 1'b1;
          base_seq = base_seq + 1'b1;
        end
        if (deliver) add_expected(KIND_DELIVER, data, '0, '0, 1'b1);
        else add_expected(KIND_STATUS, '0, '0, '0, 1'b1);
      end
      ACT_TIMEOUT: begin
        if (sent_count == 0) begin
          add_expected(KIND_STATUS, '0, '0, '0, 1'b1);
        end else begin
          slot = base_seq;
          for (i = 0; i < sent_count; i++) begin
            add_expected(KIND_TX, frame_store[slot], slot, expect_seq - 1'b1,
                         i == sent_count - 1);
            slot = slot + 1'b1;
          end
          next_seq = slot;
        end
      end
      default: begin
        add_expected(KIND_STATUS, '0, '0, '0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      next_seq   = '0;
      base_seq   = '0;
      expect_seq = '0;
      sent_count = '0;
      expected_results.delete();
    end else begin
      // results leave before the transfer at this edge is predicted
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, payload", out_payload, '0);
        end else begin
          head = expected_results.pop_front();
          if (out_kind !== head.kind) report_mismatch("kind", out_kind, head.kind);
          if (out_payload !== head.payload)
            report_mismatch("payload", out_payload, head.payload);
          if (out_seq !== head.seq) report_mismatch("seq", out_seq, head.seq);
          if (out_ack !== head.ack) report_mismatch("ack", out_ack, head.ack);
          if (out_window_open !== head.window_open)
            report_mismatch("window_open", out_window_open, head.window_open);
          if (out_last !== head.last) report_mismatch("last", out_last, head.last);
        end
      end
      if (start && !busy)
        predict_link(in_action, in_packet_data, in_frame_seq, in_frame_ack);
    end
    pending <= expected_results.size();
  end

endmodule

// ----- test/tb.sv -----
// top of the go-back-n link endpoint testbench: clock, reset, command stimulus and verdict
// depends on gbn_pkg, go_back_n_link_endpoint and go_back_n_link_endpoint_checker
`timescale 1ns / 1ps

module tb;
  import gbn_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [ACT_W-1:0]  in_action = ACT_CKSUM;
  logic [DATA_W-1:0] in_packet_data = '0;
  logic [SEQ_W-1:0]  in_frame_seq = '0;
  logic [SEQ_W-1:0]  in_frame_ack = '0;
  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [DATA_W-1:0] out_payload;
  logic [SEQ_W-1:0]  out_seq;
  logic [SEQ_W-1:0]  out_ack;
  logic              out_window_open;
  logic              out_last;
  int                mismatches;
  int                pending;
  int                cycles = 0;
  logic [SEQ_W-1:0]  peer_seq = '0;

  always #2 clk = ~clk;

  go_back_n_link_endpoint dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_packet_data(in_packet_data),
    .in_frame_seq(in_frame_seq), .in_frame_ack(in_frame_ack),
    .out_valid(out_valid), .out_kind(out_kind), .out_payload(out_payload),
    .out_seq(out_seq), .out_ack(out_ack), .out_window_open(out_window_open),
    .out_last(out_last)
  );

  go_back_n_link_endpoint_checker link_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_packet_data(in_packet_data),
    .in_frame_seq(in_frame_seq), .in_frame_ack(in_frame_ack),
    .out_valid(out_valid), .out_kind(out_kind), .out_payload(out_payload),
    .out_seq(out_seq), .out_ack(out_ack), .out_window_open(out_window_open),
    .out_last(out_last), .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("go_back_n_link_endpoint test failed");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SEQ_W-1:0] rand_seq();
    return SEQ_W'($urandom_range(SEQ_MOD - 1));
  endfunction

  // starts at a rising edge, returns at the edge of the transfer
  task automatic issue_cmd(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] data,
                           input logic [SEQ_W-1:0] fseq, input logic [SEQ_W-1:0] fack);
    start          <= 1'b1;
    in_action      <= act;
    in_packet_data <= data;
    in_frame_seq   <= fseq;
    in_frame_ack   <= fack;
    do @(posedge clk); while (busy);
    if (act == ACT_RECV && fseq == peer_seq) peer_seq = peer_seq + 1'b1;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int               n;
    int               r;
    logic [SEQ_W-1:0] fseq;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    issue_cmd(ACT_TIMEOUT, '0, '0, '0);
    issue_cmd(ACT_CKSUM, '1, 3'd7, 3'd7);
    issue_cmd(ACT_SEND, '0, '0, '0);
    issue_cmd(ACT_SEND, '1, 3'd7, 3'd7);
    for (n = 0; n < 5; n++) issue_cmd(ACT_SEND, rand_word(), '0, '0);
    issue_cmd(ACT_SEND, '1, '0, '0);
    issue_cmd(ACT_TIMEOUT, '1, 3'd7, 3'd7);
    issue_cmd(ACT_RECV, rand_word(), 3'd7, 3'd3);
    issue_cmd(ACT_RECV, '0, 3'd0, 3'd7);
    issue_cmd(ACT_RECV, '1, 3'd1, 3'd6);
    issue_cmd(ACT_RECV, rand_word(), 3'd2, 3'd0);
    issue_cmd(ACT_TIMEOUT, '0, '0, '0);
    issue_cmd(ACT_CKSUM, '0, '0, '0);
    for (n = 0; n < 4; n++) issue_cmd(ACT_SEND, rand_word(), '0, '0);
    issue_cmd(ACT_TIMEOUT, '0, '0, '0);
    issue_cmd(ACT_RECV, rand_word(), peer_seq, 3'd4);
    drain_results();

    // random part
    for (n = 0; n < 100; n++) begin
      if ((n < 30 || n > 65) && $urandom_range(99) < 8) begin
        start <= 1'b0;
        repeat ($urandom_range(3, 1)) @(posedge clk);
      end
      r = $urandom_range(99);
      if (r < 40) begin
        issue_cmd(ACT_SEND, rand_word(), rand_seq(), rand_seq());
      end else if (r < 75) begin
        fseq = ($urandom_range(9) < 7) ? peer_seq : rand_seq();
        issue_cmd(ACT_RECV, rand_word(), fseq, rand_seq());
      end else if (r < 88) begin
        issue_cmd(ACT_TIMEOUT, rand_word(), rand_seq(), rand_seq());
      end else begin
        issue_cmd(ACT_CKSUM, rand_word(), rand_seq(), rand_seq());
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("go_back_n_link_endpoint test passed");
    end else begin
      $display("go_back_n_link_endpoint test failed");
    end
    $finish;
  end

endmodule
